>>> hdl/sfdlw_pkg.sv
// shared types, constants and codes of the sensor frame decoder with link watchdog
// no dependencies; used by every other file of the block

package sfdlw_pkg;

    localparam int UPTIME_WIDTH_DEF = 32;

    localparam int ID_W    = 11;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int KIND_W  = 3;
    localparam int CHAN_W  = 4;
    localparam int READ_W  = 32;
    localparam int STAT_W  = 8;
    localparam int PERIOD_W = 16;
    localparam int VER_W   = 8;

    localparam logic [ID_W-1:0] ID_BEAT     = 11'h010;
    localparam logic [ID_W-1:0] ID_PRESS_LO = 11'h100;
    localparam logic [ID_W-1:0] ID_PRESS_HI = 11'h101;
    localparam logic [ID_W-1:0] ID_TEMP     = 11'h102;
    localparam logic [ID_W-1:0] ID_FORCE    = 11'h103;

    localparam logic [LEN_W-1:0] LEN_READ  = 4'd8;
    localparam logic [LEN_W-1:0] LEN_FORCE = 4'd5;

    localparam logic [KIND_W-1:0] KIND_PRESS  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TEMP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FORCE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEALTH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BEAT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LOST   = 3'd5;

    localparam logic [15:0] FAULT_FLAG = 16'h0001;
    localparam logic [15:0] NO_FAULT   = 16'h0000;

    localparam logic [CHAN_W-1:0] CHAN_FIRST_LO = 4'd1;
    localparam logic [CHAN_W-1:0] CHAN_FIRST_HI = 4'd5;

    // apb register map
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam logic [2:0] REG_WATCHDOG = 3'd0;
    localparam logic [2:0] REG_REPORT   = 3'd1;
    localparam logic [2:0] REG_BEAT     = 3'd2;
    localparam logic [2:0] REG_VER_MAJ  = 3'd3;
    localparam logic [2:0] REG_VER_MIN  = 3'd4;

    localparam logic [PERIOD_W-1:0] WATCHDOG_RST = 16'd3000;
    localparam logic [PERIOD_W-1:0] REPORT_RST   = 16'd200;
    localparam logic [PERIOD_W-1:0] BEAT_RST     = 16'd1000;
    localparam logic [VER_W-1:0]    VER_MAJ_RST  = 8'd3;
    localparam logic [VER_W-1:0]    VER_MIN_RST  = 8'd0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PERIOD_W-1:0] watchdog_ms;
        logic [PERIOD_W-1:0] report_period_ms;
        logic [PERIOD_W-1:0] beat_period_ms;
        logic [VER_W-1:0]    version_major;
        logic [VER_W-1:0]    version_minor;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_READ  = 2'd0,
        JOB_FORCE = 2'd1,
        JOB_EVENT = 2'd2
    } job_type_t;

    // event flags in emit order: lost, health, beat
    typedef struct packed {
        job_type_t         jtype;
        logic              link_ok;
        logic              temp;
        logic              hi_bank;
        logic [2:0]        events;
        logic [DATA_W-1:0] data;
    } job_t;

endpackage

>>> hdl/sfdlw_if.sv
// request and result channel interfaces with valid/ready handshake
// depends on sfdlw_pkg

interface sfdlw_in_if;
    import sfdlw_pkg::*;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_len;
    logic [DATA_W-1:0] frame_bytes;

    modport source (output valid, req_type, frame_id, frame_len, frame_bytes, input ready);
    modport sink   (input valid, req_type, frame_id, frame_len, frame_bytes, output ready);
endinterface

interface sfdlw_out_if;
    import sfdlw_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        out_kind;
    logic [CHAN_W-1:0]        channel;
    logic signed [READ_W-1:0] reading;
    logic [STAT_W-1:0]        sensor_status;
    logic                     link_ok;
    logic [DATA_W-1:0]        beat_payload;
    logic                     last_of_run;

    modport source (output valid, out_kind, channel, reading, sensor_status, link_ok,
                    beat_payload, last_of_run, input ready);
    modport sink   (input valid, out_kind, channel, reading, sensor_status, link_ok,
                    beat_payload, last_of_run, output ready);
endinterface

>>> hdl/sfdlw_cfg.sv
// apb configuration registers: watchdog, report and beat periods, version bytes
// depends on sfdlw_pkg

module sfdlw_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfdlw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfdlw_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfdlw_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output sfdlw_pkg::cfg_t                  cfg
);
    import sfdlw_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_WATCHDOG: cfg_next.watchdog_ms      = pwdata[PERIOD_W-1:0];
                REG_REPORT:   cfg_next.report_period_ms = pwdata[PERIOD_W-1:0];
                REG_BEAT:     cfg_next.beat_period_ms   = pwdata[PERIOD_W-1:0];
                REG_VER_MAJ:  cfg_next.version_major    = pwdata[VER_W-1:0];
                REG_VER_MIN:  cfg_next.version_minor    = pwdata[VER_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WATCHDOG: prdata = CFG_DATA_W'(cfg_reg.watchdog_ms);
            REG_REPORT:   prdata = CFG_DATA_W'(cfg_reg.report_period_ms);
            REG_BEAT:     prdata = CFG_DATA_W'(cfg_reg.beat_period_ms);
            REG_VER_MAJ:  prdata = CFG_DATA_W'(cfg_reg.version_major);
            REG_VER_MIN:  prdata = CFG_DATA_W'(cfg_reg.version_minor);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.watchdog_ms      <= WATCHDOG_RST;
            cfg_reg.report_period_ms <= REPORT_RST;
            cfg_reg.beat_period_ms   <= BEAT_RST;
            cfg_reg.version_major    <= VER_MAJ_RST;
            cfg_reg.version_minor    <= VER_MIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/sfdlw_front.sv
// front end: accepts requests, runs uptime and link watchdog, queues result jobs
// depends on sfdlw_pkg and sfdlw_if

module sfdlw_front #(
    parameter int UPTIME_WIDTH = sfdlw_pkg::UPTIME_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    sfdlw_in_if.sink        frame_in,
    input  sfdlw_pkg::cfg_t cfg,
    input  logic            q_full,
    output logic            push,
    output sfdlw_pkg::job_t push_job
);
    import sfdlw_pkg::*;

    logic [UPTIME_WIDTH-1:0] uptime_reg, uptime_next;
    logic [UPTIME_WIDTH-1:0] partner_reg, partner_next;
    logic [UPTIME_WIDTH-1:0] report_reg, report_next;
    logic [UPTIME_WIDTH-1:0] beat_reg, beat_next;
    logic                    fault_reg, fault_next;
    logic [UPTIME_WIDTH-1:0] now;
    logic [UPTIME_WIDTH-1:0] rep_diff;
    logic [UPTIME_WIDTH-1:0] beat_diff;
    logic [UPTIME_WIDTH-1:0] wd_diff;
    logic [63:0]             now_ext;
    logic                    accept;
    logic                    rep_due;
    logic                    beat_due;
    logic                    lost;

    assign frame_in.ready = !q_full;
    assign accept         = frame_in.valid & frame_in.ready;

    assign now       = uptime_reg + UPTIME_WIDTH'(1);
    assign now_ext   = 64'(now);
    assign rep_diff  = now - report_reg;
    assign beat_diff = now - beat_reg;
    assign wd_diff   = now - partner_reg;
    assign rep_due   = rep_diff >= UPTIME_WIDTH'(cfg.report_period_ms);
    assign beat_due  = beat_diff >= UPTIME_WIDTH'(cfg.beat_period_ms);
    assign lost      = rep_due & !fault_reg & (wd_diff > UPTIME_WIDTH'(cfg.watchdog_ms));

    always_comb
    begin
        uptime_next  = uptime_reg;
        partner_next = partner_reg;
        report_next  = report_reg;
        beat_next    = beat_reg;
        fault_next   = fault_reg;
        push         = 1'b0;
        push_job     = '0;
        push_job.data    = frame_in.frame_bytes;
        push_job.link_ok = !fault_reg;
        if (accept)
        begin
            if (frame_in.req_type)
            begin
                uptime_next = now;
                if (rep_due)
                begin
                    report_next = now;
                end
                if (lost)
                begin
                    fault_next = 1'b1;
                end
                if (beat_due)
                begin
                    beat_next = now;
                end
                push             = rep_due | beat_due;
                push_job.jtype   = JOB_EVENT;
                push_job.events  = {lost, rep_due, beat_due};
                push_job.link_ok = !(fault_reg | lost);
                push_job.data    = {32'b0, now_ext[31:0]};
            end
            else if (frame_in.frame_id == ID_BEAT)
            begin
                partner_next     = uptime_reg;
                fault_next       = 1'b0;
                push             = fault_reg;
                push_job.jtype   = JOB_EVENT;
                push_job.events  = 3'b010;
                push_job.link_ok = 1'b1;
            end
            else if (frame_in.frame_id inside {ID_PRESS_LO, ID_PRESS_HI, ID_TEMP})
            begin
                push             = frame_in.frame_len >= LEN_READ;
                push_job.jtype   = JOB_READ;
                push_job.temp    = frame_in.frame_id == ID_TEMP;
                push_job.hi_bank = frame_in.frame_id == ID_PRESS_HI;
            end
            else if (frame_in.frame_id == ID_FORCE)
            begin
                push           = frame_in.frame_len >= LEN_FORCE;
                push_job.jtype = JOB_FORCE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uptime_reg  <= '0;
            partner_reg <= '0;
            report_reg  <= '0;
            beat_reg    <= '0;
            fault_reg   <= 1'b1;
        end
        else
        begin
            uptime_reg  <= uptime_next;
            partner_reg <= partner_next;
            report_reg  <= report_next;
            beat_reg    <= beat_next;
            fault_reg   <= fault_next;
        end
    end

endmodule

>>> hdl/sfdlw_queue.sv
// short job queue between front and back end, first word fall through
// depends on sfdlw_pkg

module sfdlw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sfdlw_pkg::job_t push_job,
    input  logic            pop,
    output logic            full,
    output logic            q_valid,
    output sfdlw_pkg::job_t head
);
    import sfdlw_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_pop  = pop & q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/sfdlw_back.sv
// back end: expands each queued job into its results, one per cycle unless stalled, into the output register
// depends on sfdlw_pkg and sfdlw_if

module sfdlw_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sfdlw_pkg::job_t head,
    input  sfdlw_pkg::cfg_t cfg,
    output logic            pop,
    sfdlw_out_if.source     result_out
);
    import sfdlw_pkg::*;

    logic                     out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [CHAN_W-1:0]        chan_reg, chan_next;
    logic [READ_W-1:0]        read_reg, read_next;
    logic [STAT_W-1:0]        stat_reg, stat_next;
    logic                     ok_reg, ok_next;
    logic [DATA_W-1:0]        pay_reg, pay_next;
    logic                     last_reg, last_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic [2:0]               done_reg, done_next;
    logic [2:0]               pend;
    logic [2:0]               emit_bit;
    logic [15:0]              raw;
    logic                     load;

    assign load = q_valid & (!out_valid_reg | result_out.ready);
    assign pend = head.events & ~done_reg;
    assign raw  = head.data[16*cnt_reg +: 16];

    always_comb
    begin
        kind_next = KIND_HEALTH;
        chan_next = '0;
        read_next = '0;
        stat_next = '0;
        ok_next   = head.link_ok;
        pay_next  = '0;
        last_next = 1'b1;
        emit_bit  = '0;
        case (head.jtype)
            JOB_READ:
            begin
                kind_next = head.temp ? KIND_TEMP : KIND_PRESS;
                chan_next = (head.hi_bank ? CHAN_FIRST_HI : CHAN_FIRST_LO) + {2'b0, cnt_reg};
                read_next = {{16{raw[15]}}, raw};
                last_next = cnt_reg == 2'd3;
            end
            JOB_FORCE:
            begin
                kind_next = KIND_FORCE;
                read_next = head.data[31:0];
                stat_next = head.data[39:32];
            end
            JOB_EVENT:
            begin
                if (pend[2])
                begin
                    kind_next = KIND_LOST;
                    emit_bit  = 3'b100;
                    last_next = !(pend[1] | pend[0]);
                end
                else if (pend[1])
                begin
                    kind_next = KIND_HEALTH;
                    emit_bit  = 3'b010;
                    last_next = !pend[0];
                end
                else
                begin
                    kind_next = KIND_BEAT;
                    emit_bit  = 3'b001;
                    pay_next  = {cfg.version_minor, cfg.version_major,
                                 head.link_ok ? NO_FAULT : FAULT_FLAG, head.data[31:0]};
                end
            end
            default:
            begin
                kind_next = KIND_HEALTH;
            end
        endcase
    end

    always_comb
    begin
        pop            = load & last_next;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        out_valid_next = result_out.ready ? 1'b0 : out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (last_next)
            begin
                cnt_next  = '0;
                done_next = '0;
            end
            else
            begin
                cnt_next  = cnt_reg + 2'd1;
                done_next = done_reg | emit_bit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            chan_reg <= chan_next;
            read_reg <= read_next;
            stat_reg <= stat_next;
            ok_reg   <= ok_next;
            pay_reg  <= pay_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            done_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.out_kind      = kind_reg;
    assign result_out.channel       = chan_reg;
    assign result_out.reading       = read_reg;
    assign result_out.sensor_status = stat_reg;
    assign result_out.link_ok       = ok_reg;
    assign result_out.beat_payload  = pay_reg;
    assign result_out.last_of_run   = last_reg;

endmodule

>>> hdl/sensor_frame_decoder_link_watchdog.sv
// sensor frame decoder with link watchdog; jobs are queued, then results registered
// front end takes one request per cycle while its 4-entry job queue has room
// back end: one result per cycle unless stalled, 4 per readings frame, up to 3 per tick
// reset: uptime and timestamps zero, link faulted, registers at defaults, queue empty
// depends on sfdlw_pkg, sfdlw_if, sfdlw_cfg, sfdlw_front, sfdlw_queue, sfdlw_back

module sensor_frame_decoder_link_watchdog #(
    parameter int UPTIME_WIDTH = sfdlw_pkg::UPTIME_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sfdlw_in_if.sink                         frame_in,
    sfdlw_out_if.source                      result_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfdlw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfdlw_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfdlw_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);
    import sfdlw_pkg::*;

    cfg_t cfg;
    job_t push_job;
    job_t head;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;

    sfdlw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfdlw_front #(
        .UPTIME_WIDTH (UPTIME_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    sfdlw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .head     (head)
    );

    sfdlw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head       (head),
        .cfg        (cfg),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

>>> hdl/sfdlw_checker.sv
// port-level checks on the result channel of the frame decoder, bound to the top level
// depends on sfdlw_pkg and sensor_frame_decoder_link_watchdog

module sfdlw_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [sfdlw_pkg::KIND_W-1:0] out_kind,
    input logic [sfdlw_pkg::CHAN_W-1:0] channel,
    input logic                         link_ok,
    input logic [sfdlw_pkg::DATA_W-1:0] beat_payload
);
    import sfdlw_pkg::*;

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // only readings carry a channel number
    a_chan_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_kind == KIND_PRESS || out_kind == KIND_TEMP) == (channel != '0)))
        else $error("channel does not match result kind");

    // heartbeat fault flag agrees with reported link health
    a_beat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_BEAT |-> beat_payload[32] == !link_ok)
        else $error("heartbeat fault flag disagrees with link health");

    // a lost warning always reports a faulted link and no payload
    a_lost_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_LOST |-> !link_ok && beat_payload == '0)
        else $error("lost warning with healthy link or payload");

endmodule

bind sensor_frame_decoder_link_watchdog sfdlw_checker u_sfdlw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_kind     (result_out.out_kind),
    .channel      (result_out.channel),
    .link_ok      (result_out.link_ok),
    .beat_payload (result_out.beat_payload)
);

>>> test/testbench.sv
// testbench for the sensor frame decoder with link watchdog: random and directed frames and
// ticks, results checked against a local model of decoding, watchdog and heartbeat timing
// depends on sfdlw_pkg, sfdlw_if and the sensor_frame_decoder_link_watchdog rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfdlw_pkg::*;

    localparam int UPW = UPTIME_WIDTH_DEF;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  frame_len;
        logic [DATA_W-1:0] frame_bytes;
    } frame_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] chan;
        logic [READ_W-1:0] reading;
        logic [STAT_W-1:0] status;
        logic              link_ok;
        logic [DATA_W-1:0] payload;
        logic              last;
    } sensor_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sfdlw_in_if  frame_in ();
    sfdlw_out_if result_out ();

    sensor_frame_decoder_link_watchdog i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in),
        .result_out (result_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    cfg_t           cfg;
    logic [UPW-1:0] up_count;
    logic [UPW-1:0] partner_ms;
    logic [UPW-1:0] report_ms;
    logic [UPW-1:0] beat_ms;
    logic           link_faulted;
    sensor_result_t run_buf [0:3];
    int             run_n;

    frame_req_t     queued_requests [$];
    sensor_result_t due_results [$];
    int             n_issued = 0;
    int             n_accepted = 0;
    int             n_predicted = 0;
    int             n_checked = 0;
    int             n_errors = 0;
    int             send_gap;
    int             recv_stall;
    logic           steady;
    logic           hold_ready;
    frame_req_t     next_req;
    frame_req_t     seen_req;
    sensor_result_t want;

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic frame_req_t make_request(input logic t, input logic [ID_W-1:0] id,
                                                input logic [LEN_W-1:0] len,
                                                input logic [DATA_W-1:0] data);
        frame_req_t q;
        q.req_type = t;
        q.frame_id = id;
        q.frame_len = len;
        q.frame_bytes = data;
        return q;
    endfunction

    function automatic frame_req_t rand_request();
        frame_req_t       q;
        int               sel;
        logic [LEN_W-1:0] minlen;
        sel = $urandom_range(0, 99);
        q.req_type = 1'b0;
        q.frame_id = ID_W'($urandom);
        q.frame_len = LEN_W'($urandom);
        q.frame_bytes = {$urandom, $urandom};
        if (sel < 35)
        begin
            q.req_type = 1'b1;
        end
        else if (sel < 45)
        begin
            q.frame_id = ID_BEAT;
        end
        else if (sel < 85)
        begin
            if (sel < 75)
            begin
                q.frame_id = ID_PRESS_LO + ID_W'($urandom_range(0, 2));
                minlen = LEN_READ;
            end
            else
            begin
                q.frame_id = ID_FORCE;
                minlen = LEN_FORCE;
            end
            if ($urandom_range(0, 9) == 0)
                q.frame_len = LEN_W'($urandom_range(0, minlen - 1));
            else
                q.frame_len = LEN_W'($urandom_range(minlen, 15));
        end
        return q;
    endfunction

    task automatic report_error(input string msg);
        if (n_errors < 50)
            $display("error at %0t ns: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_v);
        if (got !== exp_v)
            report_error($sformatf("result %0d %s got %0h want %0h", n_checked, name, got,
                                   exp_v));
    endtask

    task automatic add_result(input logic [KIND_W-1:0] kind, input logic [CHAN_W-1:0] chan,
                              input logic [READ_W-1:0] reading,
                              input logic [STAT_W-1:0] status,
                              input logic [DATA_W-1:0] payload);
        sensor_result_t r;
        r.kind = kind;
        r.chan = chan;
        r.reading = reading;
        r.status = status;
        r.link_ok = !link_faulted;
        r.payload = payload;
        r.last = 1'b0;
        run_buf[run_n] = r;
        run_n++;
    endtask

    task automatic decode_request(input frame_req_t q);
        logic [UPW-1:0]    now;
        logic [15:0]       raw;
        logic [CHAN_W-1:0] first;
        logic [KIND_W-1:0] kind;
        run_n = 0;
        if (q.req_type)
        begin
            now = up_count + 1'b1;
            up_count = now;
            if ((now - report_ms) >= cfg.report_period_ms)
            begin
                report_ms = now;
                if (!link_faulted && (now - partner_ms) > cfg.watchdog_ms)
                begin
                    link_faulted = 1'b1;
                    add_result(KIND_LOST, '0, '0, '0, '0);
                end
                add_result(KIND_HEALTH, '0, '0, '0, '0);
            end
            if ((now - beat_ms) >= cfg.beat_period_ms)
            begin
                beat_ms = now;
                add_result(KIND_BEAT, '0, '0, '0,
                           {cfg.version_minor, cfg.version_major,
                            link_faulted ? FAULT_FLAG : NO_FAULT, now[31:0]});
            end
        end
        else if (q.frame_id == ID_BEAT)
        begin
            partner_ms = up_count;
            if (link_faulted)
            begin
                link_faulted = 1'b0;
                add_result(KIND_HEALTH, '0, '0, '0, '0);
            end
        end
        else if (q.frame_id == ID_PRESS_LO || q.frame_id == ID_PRESS_HI
                 || q.frame_id == ID_TEMP)
        begin
            if (q.frame_len >= LEN_READ)
            begin
                kind = (q.frame_id == ID_TEMP) ? KIND_TEMP : KIND_PRESS;
                first = (q.frame_id == ID_PRESS_HI) ? CHAN_FIRST_HI : CHAN_FIRST_LO;
                for (int i = 0; i < 4; i++)
                begin
                    raw = q.frame_bytes[16*i +: 16];
                    add_result(kind, first + CHAN_W'(i), {{16{raw[15]}}, raw}, '0, '0);
                end
            end
        end
        else if (q.frame_id == ID_FORCE && q.frame_len >= LEN_FORCE)
        begin
            add_result(KIND_FORCE, '0, q.frame_bytes[31:0], q.frame_bytes[39:32], '0);
        end
        for (int i = 0; i < run_n; i++)
        begin
            if (i == run_n - 1)
                run_buf[i].last = 1'b1;
            due_results.push_back(run_buf[i]);
            n_predicted++;
        end
    endtask

    task automatic offer(input frame_req_t q);
        queued_requests.push_back(q);
        n_issued++;
    endtask

    task automatic drain();
        wait (n_accepted == n_issued);
        wait (n_checked == n_predicted);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        logic [CFG_DATA_W-1:0] wdata;
        wdata = $urandom;
        wdata[15:0] = value;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 2'b00});
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WATCHDOG: cfg.watchdog_ms = value;
            REG_REPORT:   cfg.report_period_ms = value;
            REG_BEAT:     cfg.beat_period_ms = value;
            REG_VER_MAJ:  cfg.version_major = value[7:0];
            REG_VER_MIN:  cfg.version_minor = value[7:0];
            default:      ;
        endcase
    endtask

    task automatic write_config(input logic [15:0] wd, input logic [15:0] rep,
                                input logic [15:0] beat, input logic [7:0] maj,
                                input logic [7:0] min);
        write_reg(REG_WATCHDOG, wd);
        write_reg(REG_REPORT, rep);
        write_reg(REG_BEAT, beat);
        write_reg(REG_VER_MAJ, {8'($urandom), maj});
        write_reg(REG_VER_MIN, {8'($urandom), min});
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            offer(rand_request());
        drain();
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_in.valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!frame_in.valid || frame_in.ready)
        begin
            if (send_gap != 0)
            begin
                frame_in.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (queued_requests.size() != 0)
            begin
                next_req = queued_requests.pop_front();
                frame_in.valid <= 1'b1;
                frame_in.req_type <= next_req.req_type;
                frame_in.frame_id <= next_req.frame_id;
                frame_in.frame_len <= next_req.frame_len;
                frame_in.frame_bytes <= next_req.frame_bytes;
                send_gap <= steady ? 0 : pick_gap();
            end
            else
            begin
                frame_in.valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_out.ready <= 1'b0;
            recv_stall <= 0;
        end
        else if (hold_ready)
        begin
            result_out.ready <= 1'b0;
        end
        else if (recv_stall != 0)
        begin
            result_out.ready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end
        else
        begin
            result_out.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
                recv_stall <= pick_gap();
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_in.valid && frame_in.ready)
            begin
                seen_req.req_type = frame_in.req_type;
                seen_req.frame_id = frame_in.frame_id;
                seen_req.frame_len = frame_in.frame_len;
                seen_req.frame_bytes = frame_in.frame_bytes;
                decode_request(seen_req);
                n_accepted++;
            end
            if (result_out.valid && result_out.ready)
            begin
                if (due_results.size() == 0)
                begin
                    report_error("result arrived with none expected");
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("out_kind", result_out.out_kind, want.kind);
                    check_field("channel", result_out.channel, want.chan);
                    check_field("reading", $unsigned(result_out.reading), want.reading);
                    check_field("sensor_status", result_out.sensor_status, want.status);
                    check_field("link_ok", result_out.link_ok, want.link_ok);
                    check_field("beat_payload", result_out.beat_payload, want.payload);
                    check_field("last_of_run", result_out.last_of_run, want.last);
                    n_checked++;
                end
            end
        end
    end

    // long receiver hold-off while requests keep coming
    initial
    begin
        wait (n_accepted >= 60);
        @(posedge clk);
        hold_ready <= 1'b1;
        repeat (80) @(posedge clk);
        hold_ready <= 1'b0;
    end

    initial
    begin
        #4_800_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        frame_in.valid = 1'b0;
        frame_in.req_type = 1'b0;
        frame_in.frame_id = '0;
        frame_in.frame_len = '0;
        frame_in.frame_bytes = '0;
        result_out.ready = 1'b0;
        steady = 1'b0;
        hold_ready = 1'b0;
        cfg.watchdog_ms = WATCHDOG_RST;
        cfg.report_period_ms = REPORT_RST;
        cfg.beat_period_ms = BEAT_RST;
        cfg.version_major = VER_MAJ_RST;
        cfg.version_minor = VER_MIN_RST;
        up_count = '0;
        partner_ms = '0;
        report_ms = '0;
        beat_ms = '0;
        link_faulted = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // decoding at reset settings, link starts faulted
        offer(make_request(1'b0, ID_PRESS_LO, LEN_READ, 64'h8000_7fff_ffff_0000));
        offer(make_request(1'b0, ID_PRESS_HI, LEN_READ, {$urandom, $urandom}));
        offer(make_request(1'b0, ID_TEMP, 4'hf, 64'h0001_fffe_8001_7ffe));
        offer(make_request(1'b0, ID_PRESS_LO, 4'd7, {$urandom, $urandom}));
        offer(make_request(1'b0, ID_FORCE, LEN_FORCE, 64'h0000_00ff_8000_0000));
        offer(make_request(1'b0, ID_FORCE, 4'd4, {$urandom, $urandom}));
        offer(make_request(1'b0, ID_FORCE, 4'd8, '1));
        offer(make_request(1'b0, 11'h7ff, 4'd8, '1));
        offer(make_request(1'b0, 11'h000, 4'd0, '0));
        offer(make_request(1'b1, 11'h7ff, 4'hf, '1));
        offer(make_request(1'b0, ID_BEAT, 4'd0, '0));
        offer(make_request(1'b0, ID_BEAT, 4'd8, '1));
        offer(make_request(1'b1, '0, '0, '0));
        drain();

        // zero watchdog, every tick reports and beats
        write_config(16'd0, 16'd1, 16'd1, 8'hff, 8'hff);
        offer(make_request(1'b1, '0, '0, '0));
        offer(make_request(1'b1, '1, '1, '1));
        offer(make_request(1'b0, ID_BEAT, 4'd3, {$urandom, $urandom}));
        offer(make_request(1'b1, '0, '0, '0));
        offer(make_request(1'b0, ID_BEAT, 4'hf, '1));
        offer(make_request(1'b0, ID_TEMP, LEN_READ, {$urandom, $urandom}));
        offer(make_request(1'b1, '0, '0, '0));
        drain();

        write_config(16'($urandom_range(0, 12)), 16'($urandom_range(0, 5)),
                     16'($urandom_range(0, 8)), 8'($urandom), 8'($urandom));
        run_random(50);

        // largest periods with no idling on either side
        write_config(16'hffff, 16'hffff, 16'hffff, 8'h00, 8'h00);
        steady <= 1'b1;
        run_random(40);
        steady <= 1'b0;

        for (int p = 0; p < 3; p++)
        begin
            write_config(16'($urandom_range(1, 30)), 16'($urandom_range(1, 10)),
                         16'($urandom_range(1, 10)), 8'($urandom), 8'($urandom));
            run_random(45);
        end

        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
